// ===== hw/rtl/gwpm_pkg.sv =====
`default_nettype none

package gwpm_pkg;

  localparam int CHANNELS_DEF       = 8;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  localparam int SAMPLE_W  = 32;
  localparam int CHANNEL_W = 3;
  localparam int GAIN_W    = 24;
  localparam int PEAK_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [1:0] sample_format_t;
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam sample_format_t FMT_S16 = 2'd0;
  localparam sample_format_t FMT_S24 = 2'd1;
  localparam sample_format_t FMT_S32 = 2'd2;

  localparam cfg_index_t REG_SAMPLE_FORMAT    = 2'd0;
  localparam cfg_index_t REG_PASSTHROUGH      = 2'd1;
  localparam cfg_index_t REG_PEAK_ATTENUATION = 2'd2;

  localparam sample_format_t SAMPLE_FORMAT_RST = FMT_S32;
  localparam logic           PASSTHROUGH_RST   = 1'b0;
  localparam logic [4:0]     PEAK_ATTEN_RST    = 5'd0;

endpackage

`default_nettype wire

// ===== hw/rtl/gain_with_peak_meter.sv =====
`default_nettype none

// Volume gain with per-channel peak meter. Each request carries a sample, its
// channel and an unsigned gain with GAIN_FRAC_BITS fraction bits; the result
// is the sample times the gain, rounded to nearest (ties up) and saturated to
// the selected 16, 24 or 32 bit format, or the raw word in passthrough mode,
// together with the channel's updated peak (zero for a channel outside
// CHANNELS). A request passes from an input register to the output register,
// and one request is taken every cycle unless the output stalls: the input
// register feeds one multiplier and the peak read-compare-write, which land in
// the output register and the peak store at the same edge, so back-to-back
// requests to one channel see each other's updates. Peak stores clear at
// reset. Configuration must be written through the cfg port, which is always
// ready, only while no request is in flight; the block does not enforce this.
module gain_with_peak_meter #(
  parameter int CHANNELS       = gwpm_pkg::CHANNELS_DEF,
  parameter int GAIN_FRAC_BITS = gwpm_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire  signed [gwpm_pkg::SAMPLE_W-1:0]    in_sample,
  input  wire         [gwpm_pkg::CHANNEL_W-1:0]   in_channel,
  input  wire         [gwpm_pkg::GAIN_W-1:0]      in_gain,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic signed [gwpm_pkg::SAMPLE_W-1:0]    out_sample,
  output logic        [gwpm_pkg::PEAK_W-1:0]      out_channel_peak,
  input  wire                                     cfg_valid,
  output logic                                    cfg_ready,
  input  wire         [gwpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire         [gwpm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gwpm_pkg::*;

  localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PROD_W = SAMPLE_W + 1 + GAIN_W + 1;
  localparam int SHW_W  = PEAK_W + 40;

  // configuration
  sample_format_t sample_format_r;
  logic           passthrough_r;
  logic [4:0]     peak_atten_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_format_r <= SAMPLE_FORMAT_RST;
      passthrough_r   <= PASSTHROUGH_RST;
      peak_atten_r    <= PEAK_ATTEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLE_FORMAT:    sample_format_r <= cfg_data[1:0];
        REG_PASSTHROUGH:      passthrough_r   <= cfg_data[0];
        REG_PEAK_ATTENUATION: peak_atten_r    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic                        s1_valid_r;
  logic signed [SAMPLE_W-1:0]  s1_sample_r;
  logic [CHANNEL_W-1:0]        s1_channel_r;
  logic [GAIN_W-1:0]           s1_gain_r;
  logic                        advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample_r  <= in_sample;
      s1_channel_r <= in_channel;
      s1_gain_r    <= in_gain;
    end
  end

  // datapath
  logic signed [SAMPLE_W:0]    x_ext;
  logic signed [SAMPLE_W:0]    x_neg;
  logic signed [PROD_W-1:0]    hi_lim;
  logic signed [PROD_W-1:0]    lo_lim;
  logic [5:0]                  pshift;
  logic signed [GAIN_W:0]      gain_s;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    rnd;
  logic signed [PROD_W-1:0]    y;
  logic signed [SAMPLE_W-1:0]  y_sat;
  logic [PEAK_W-1:0]           mag;
  logic [SHW_W-1:0]            mag_wide;
  logic [PEAK_W-1:0]           mag_sat;
  logic                        in_range;
  logic [CH_IW-1:0]            ch_idx;
  logic [PEAK_W-1:0]           peak_rd;
  logic [PEAK_W-1:0]           peak_nxt;
  logic signed [SAMPLE_W-1:0]  out_sample_nxt;
  logic [PEAK_W-1:0]           out_peak_nxt;

  always_comb begin
    case (sample_format_r)
      FMT_S16: begin
        x_ext  = {{17{s1_sample_r[15]}}, s1_sample_r[15:0]};
        hi_lim = PROD_W'(32767);
        lo_lim = -PROD_W'(32768);
        pshift = 6'd16;
      end
      FMT_S24: begin
        x_ext  = {{9{s1_sample_r[23]}}, s1_sample_r[23:0]};
        hi_lim = PROD_W'(8388607);
        lo_lim = -PROD_W'(8388608);
        pshift = 6'd8 + {1'b0, peak_atten_r};
      end
      default: begin
        x_ext  = {s1_sample_r[31], s1_sample_r};
        hi_lim = PROD_W'(64'sd2147483647);
        lo_lim = -PROD_W'(64'sd2147483648);
        pshift = {1'b0, peak_atten_r};
      end
    endcase
  end

  assign gain_s = $signed({1'b0, s1_gain_r});
  assign prod   = x_ext * gain_s;
  assign rnd    = prod + (PROD_W'(1) <<< (GAIN_FRAC_BITS - 1));
  assign y      = rnd >>> GAIN_FRAC_BITS;

  always_comb begin
    if (y > hi_lim) begin
      y_sat = hi_lim[SAMPLE_W-1:0];
    end else if (y < lo_lim) begin
      y_sat = lo_lim[SAMPLE_W-1:0];
    end else begin
      y_sat = y[SAMPLE_W-1:0];
    end
  end

  assign out_sample_nxt = passthrough_r ? s1_sample_r : y_sat;

  assign x_neg    = -x_ext;
  assign mag      = x_ext[SAMPLE_W] ? x_neg[PEAK_W-1:0] : x_ext[PEAK_W-1:0];
  assign mag_wide = {40'd0, mag} << pshift;
  assign mag_sat  = (|mag_wide[SHW_W-1:PEAK_W]) ? '1 : mag_wide[PEAK_W-1:0];

  // peak store
  logic [PEAK_W-1:0] peak_store_r [CHANNELS];

  assign in_range = ({29'd0, s1_channel_r} < 32'(CHANNELS));
  assign ch_idx   = s1_channel_r[CH_IW-1:0];
  assign peak_rd  = in_range ? peak_store_r[ch_idx] : '0;
  assign peak_nxt = (mag_sat > peak_rd) ? mag_sat : peak_rd;
  assign out_peak_nxt = in_range ? peak_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        peak_store_r[i] <= '0;
      end
    end else if (s1_valid_r && advance && in_range) begin
      peak_store_r[ch_idx] <= peak_nxt;
    end
  end

  // output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [PEAK_W-1:0]          out_channel_peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_sample_r       <= out_sample_nxt;
      out_channel_peak_r <= out_peak_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_channel_peak = out_channel_peak_r;

  // checks
  a_peak_covers_mag: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && in_range) |=> (out_channel_peak_r >= $past(mag_sat)))
    else $error("peak below current magnitude");

  a_peak_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && !in_range) |=> (out_channel_peak_r == '0))
    else $error("peak nonzero for channel out of range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with empty stage");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages full");

  a_peak_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> $stable(s1_sample_r) && $stable(s1_channel_r))
    else $error("input stage changed while stalled");

endmodule

`default_nettype wire

// ===== bench/gain_with_peak_meter_tb.sv =====
`timescale 1ns / 100ps

module gain_with_peak_meter_tb;
  import gwpm_pkg::*;

  localparam int FRAC_BITS   = GAIN_FRAC_BITS_DEF;
  localparam int NUM_CH      = CHANNELS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 100;
  localparam sample_format_t FMT_UNUSED = 2'd3;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic [PEAK_W-1:0]   peak;
  } scaled_sample_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [CHANNEL_W-1:0]      in_channel;
  logic [GAIN_W-1:0]         in_gain;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic [PEAK_W-1:0]         out_channel_peak;
  logic                      cfg_valid;
  logic                      cfg_ready;
  cfg_index_t                cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  // shadow of the block's registers and peak meters
  sample_format_t    fmt_reg   = SAMPLE_FORMAT_RST;
  logic              pass_reg  = PASSTHROUGH_RST;
  logic [4:0]        atten_reg = PEAK_ATTEN_RST;
  logic [PEAK_W-1:0] peak_mem [NUM_CH];

  scaled_sample_t pending_results[$];
  int mismatch_count = 0;
  int cycle_count    = 0;
  int hold_off       = 0;
  logic tx_burst     = 1'b0;
  logic rx_free      = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gain_with_peak_meter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_channel       (in_channel),
    .in_gain          (in_gain),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample       (out_sample),
    .out_channel_peak (out_channel_peak),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  function automatic scaled_sample_t scale_and_meter(input logic [31:0] raw,
                                                     input logic [2:0] ch,
                                                     input logic [23:0] gain);
    logic signed [31:0] sx;
    longint x, g, prod, y, lo, hi;
    longint unsigned mag;
    int bits, pshift;
    scaled_sample_t r;
    case (fmt_reg)
      FMT_S16: begin
        bits = 16;
        pshift = 16;
      end
      FMT_S24: begin
        bits = 24;
        pshift = 8 + atten_reg;
      end
      default: begin
        bits = 32;
        pshift = atten_reg;
      end
    endcase
    sx = raw << (32 - bits);
    sx = sx >>> (32 - bits);
    x  = sx;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (pass_reg) begin
      r.sample = raw;
    end else begin
      g    = gain;
      prod = x * g;
      y    = prod >>> (FRAC_BITS - 1);
      y    = (y + 1) >>> 1;
      if (y > hi) y = hi;
      if (y < lo) y = lo;
      r.sample = y[31:0];
    end
    mag = (x < 0) ? -x : x;
    mag = mag << pshift;
    if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
    if (ch < NUM_CH) begin
      if (mag[31:0] > peak_mem[ch]) peak_mem[ch] = mag[31:0];
      r.peak = peak_mem[ch];
    end else begin
      r.peak = '0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] random_sample(input int phase);
    logic [31:0] corner [9] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h007F_FFFF,
                                32'h0080_0000, 32'h0000_7FFF, 32'h0000_8000,
                                32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000};
    int pick;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    v = $urandom;
    if (pick < 12) begin
      v = corner[$urandom_range(0, 8)];
      if ($urandom_range(0, 1)) v[31:24] = 8'($urandom);
    end else if (pick >= 12 + ((phase >= 6) ? 30 : 0)) begin
      v = $signed(v) >>> $urandom_range(10, 28);
      if ($urandom_range(0, 3) == 0) v[31:16] = 16'($urandom);
    end
    return v;
  endfunction

  function automatic logic [23:0] random_gain();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 16) return 24'hFF_FFFF;
    if (pick < 50) return 24'($urandom_range(24'h00_4000, 24'h02_4000));
    return 24'($urandom_range(0, 24'hFF_FFFF));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(input logic [31:0] s, input logic [2:0] ch,
                             input logic [23:0] g);
    int gap;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_sample  = s;
    in_channel = ch;
    in_gain    = g;
    in_valid   = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(scale_and_meter(s, ch, g));
    @(negedge clk);
  endtask

  // only while idle: no request pending, every result delivered
  task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SAMPLE_FORMAT:    fmt_reg   = val[1:0];
      REG_PASSTHROUGH:      pass_reg  = val[0];
      REG_PEAK_ATTENUATION: atten_reg = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input sample_format_t fmt, input logic pass,
                           input logic [4:0] atten);
    write_reg(REG_SAMPLE_FORMAT, {30'd0, fmt});
    write_reg(REG_PASSTHROUGH, {31'd0, pass});
    write_reg(REG_PEAK_ATTENUATION, {27'd0, atten});
  endtask

  // reset configuration: 32-bit format, gain applied, no attenuation
  task automatic test_rounding_and_saturation();
    send_sample(32'h0000_0001, 3'd0, 24'h00_8000);
    send_sample(32'hFFFF_FFFF, 3'd0, 24'h00_8000);
    send_sample(32'h0000_0003, 3'd1, 24'h00_8000);
    send_sample(32'hFFFF_FFFD, 3'd1, 24'h00_8000);
    send_sample(32'h1234_5678, 3'd2, 24'h01_0000);
    send_sample(32'h1234_5678, 3'd2, 24'h00_0000);
    send_sample(32'h7FFF_FFFF, 3'd7, 24'hFF_FFFF);
    send_sample(32'h8000_0000, 3'd7, 24'hFF_FFFF);
    send_sample(32'h8000_0000, 3'd6, 24'h01_0000);
  endtask

  task automatic test_sample_formats();
    configure(FMT_S16, 1'b0, 5'd0);
    send_sample(32'hABCD_7FFF, 3'd3, 24'hFF_FFFF);
    send_sample(32'h0000_8000, 3'd3, 24'h02_0000);
    configure(FMT_S24, 1'b0, 5'd31);
    send_sample(32'hFF80_0000, 3'd4, 24'h01_0000);
    configure(FMT_S24, 1'b0, 5'd0);
    send_sample(32'h5A00_0001, 3'd5, 24'h01_8000);
    configure(FMT_UNUSED, 1'b0, 5'd31);
    send_sample(32'h0000_0001, 3'd5, 24'h01_0000);
    send_sample(32'hC000_0000, 3'd4, 24'h00_C000);
  endtask

  task automatic test_passthrough();
    configure(FMT_S16, 1'b1, 5'd0);
    send_sample(32'hDEAD_8001, 3'd0, 24'h12_3456);
    configure(FMT_S24, 1'b1, 5'd7);
    send_sample(32'h80FF_FFFF, 3'd1, 24'h00_0000);
    configure(FMT_S32, 1'b1, 5'd0);
    send_sample(32'h7FFF_FFFF, 3'd2, 24'hFF_FFFF);
  endtask

  // output stalled while requests keep coming: the block must fill up
  task automatic test_input_stall();
    int n;
    configure(FMT_S24, 1'b0, 5'd3);
    tx_burst = 1'b1;
    hold_off = 300;
    for (n = 0; n < 50; n++)
      send_sample(random_sample(0), 3'($urandom_range(0, 7)), random_gain());
    tx_burst = 1'b0;
  endtask

  task automatic test_random_traffic();
    int phase, n;
    logic [4:0] atten;
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 3)
        0:       atten = 5'd0;
        1:       atten = 5'd31;
        default: atten = 5'($urandom_range(1, 30));
      endcase
      configure(sample_format_t'(phase % 4), (phase % 5) == 3, atten);
      tx_burst = (phase % 3) == 1;
      rx_free  = (phase % 4) == 2;
      for (n = 0; n < 92; n++)
        send_sample(random_sample(phase), 3'($urandom_range(0, 7)), random_gain());
    end
    tx_burst = 1'b0;
    rx_free  = 1'b0;
  endtask

  initial begin
    int rx_gap;
    rx_gap    = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready = 1'b0;
        hold_off--;
      end else if (rx_gap > 0) begin
        out_ready = 1'b0;
        rx_gap--;
      end else begin
        out_ready = 1'b1;
        if (!rx_free && $urandom_range(0, 5) == 0) rx_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_results
    scaled_sample_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_sample, out_channel_peak);
      end else begin
        want = pending_results.pop_front();
        if (out_sample !== want.sample)
          report_mismatch("out_sample", out_sample, want.sample);
        if (out_channel_peak !== want.peak)
          report_mismatch("out_channel_peak", out_channel_peak, want.peak);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    foreach (peak_mem[i]) peak_mem[i] = '0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_sample  = '0;
    in_channel = '0;
    in_gain    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_SAMPLE_FORMAT;
    cfg_data   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_rounding_and_saturation();
    test_sample_formats();
    test_passthrough();
    test_input_stall();
    test_random_traffic();

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
